// ----- hdl/unwrapped_angular_span_unit_defines.svh -----
// Assertion macros for the angular span unit.
// Uses clk and rst of the including module; no other dependencies.
`ifndef UNWRAPPED_ANGULAR_SPAN_UNIT_DEFINES_SVH
`define UNWRAPPED_ANGULAR_SPAN_UNIT_DEFINES_SVH

// same-cycle implication
`define UAS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/uas_pkg.sv -----
// Shared types and constants for the angular span unit.
// No dependencies.
package uas_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_UPD,
    ST_CLOSE,
    ST_SPAN,
    ST_MUL,
    ST_DONE
  } uas_state_t;

  localparam logic REG_GAIN_K = 1'b0;
  localparam logic REG_GAIN_H = 1'b1;

  localparam logic [2:0] MUL_KH   = 3'd0;
  localparam logic [2:0] MUL_KHS  = 3'd1;
  localparam logic [2:0] MUL_P00  = 3'd2;
  localparam logic [2:0] MUL_P01  = 3'd3;
  localparam logic [2:0] MUL_P10  = 3'd4;
  localparam logic [2:0] MUL_P11  = 3'd5;
  localparam logic [2:0] MUL_LAST = 3'd6;

  localparam logic [15:0] GAIN_RESET = 16'd256;

  // 2*pi*2^32, split into 32-bit halves
  localparam logic [31:0] TWO_PI_LO = 32'd1216271633;
  localparam logic [31:0] TWO_PI_HI = 32'd6;

  localparam logic signed [23:0] RUN_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] RUN_MIN = -24'sh800000;

  localparam logic [26:0] SCALED_CAP = 27'h7FFFFFF;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/unwrapped_angular_span_unit.sv -----
// Angular span unit: CORDIC atan2 per vertex, unwrap, min/max, scaled span.
// A vertex passes through accept, the CORDIC steps (one CORDIC step per cycle) and update.
// A last vertex adds closure, span, a 7-step shared 32x32 multiply and result load.
// Results leave through an output register; input is not taken while a vertex is in work.
// Synchronous reset: gains to 256, polygon state to zero, no result pending.
`include "unwrapped_angular_span_unit_defines.svh"

module unwrapped_angular_span_unit #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic               last_vertex,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [16:0]        span_angle,
  output logic [26:0]        scaled_result,
  output logic               origin_hit
);

  localparam int CW     = 16 + CORDIC_STEPS + 3;
  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int SPAN_W = ANGLE_BITS + 1;
  localparam int KHS_W  = 32 + SPAN_W;
  localparam int RND_SH = 40 + ANGLE_BITS;
  localparam int ACC_W  = 68 + ANGLE_BITS;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [24:0] FULL_TURN = 25'(1) << ANGLE_BITS;
  localparam logic [31:0] Z_ROUND   = 32'(1) << (31 - ANGLE_BITS);
  localparam logic [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (RND_SH - 1);

  uas_pkg::uas_state_t state, state_next;

  logic [15:0] gain_k, gain_h;

  logic signed [CW-1:0] cx, cy;
  logic [31:0]          cz;
  logic [STEP_W-1:0]    step_cnt;
  logic                 vtx_origin, vtx_last;

  logic [ANGLE_BITS-1:0] first_angle, previous_angle;
  logic signed [23:0]    running_angle, lowest_angle, highest_angle;
  logic                  polygon_started, origin_seen;

  logic [SPAN_W-1:0]  span_q;
  logic [2:0]         mul_step;
  logic [63:0]        prod;
  logic [KHS_W-1:0]   khs;
  logic [ACC_W-1:0]   acc;

  // input load
  logic signed [CW-1:0] x_ext, y_ext, x_init, y_init;
  logic                 x_neg;

  assign x_ext  = CW'(coord_x) <<< CORDIC_STEPS;
  assign y_ext  = CW'(coord_y) <<< CORDIC_STEPS;
  assign x_neg  = coord_x[15];
  assign x_init = x_neg ? -x_ext : x_ext;
  assign y_init = x_neg ? -y_ext : y_ext;

  // CORDIC step
  logic signed [CW-1:0] xs, ys;
  logic [31:0]          atan_step;

  assign xs        = cx >>> step_cnt;
  assign ys        = cy >>> step_cnt;
  assign atan_step = uas_pkg::atan_lut(5'(step_cnt));

  // vertex angle
  logic [31:0]           z_rnd;
  logic [ANGLE_BITS-1:0] vtx_angle;

  assign z_rnd     = cz + Z_ROUND;
  assign vtx_angle = vtx_origin ? '0 : z_rnd[31:32-ANGLE_BITS];

  // shared advance unit
  logic [ANGLE_BITS-1:0] adv_to, adv_d;
  logic [24:0]           adv_sum;
  logic signed [23:0]    adv_run, adv_lo, adv_hi;

  assign adv_to  = (state == uas_pkg::ST_CLOSE) ? first_angle : vtx_angle;
  assign adv_d   = adv_to - previous_angle;
  assign adv_sum = {running_angle[23], running_angle}
                 + {{(25 - ANGLE_BITS){adv_d[ANGLE_BITS-1]}}, adv_d};

  always_comb begin
    unique case (adv_sum[24:23])
      2'b01:   adv_run = uas_pkg::RUN_MAX;
      2'b10:   adv_run = uas_pkg::RUN_MIN;
      default: adv_run = adv_sum[23:0];
    endcase
  end

  assign adv_lo = (adv_run < lowest_angle)  ? adv_run : lowest_angle;
  assign adv_hi = (adv_run > highest_angle) ? adv_run : highest_angle;

  // first vertex start value
  logic signed [23:0] start_run;

  assign start_run = (25'(vtx_angle) > 25'(uas_pkg::RUN_MAX)) ? uas_pkg::RUN_MAX
                                                             : 24'(vtx_angle);

  // span
  logic [24:0] span_diff, span_clamp, span_wide;

  assign span_diff  = 25'(highest_angle) - 25'(lowest_angle);
  assign span_clamp = (span_diff > FULL_TURN) ? FULL_TURN : span_diff;
  assign span_wide  = 25'(span_q);

  // shared multiplier
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [ACC_W-1:0] acc_add;
  logic [31:0]      khs_hi;

  assign khs_hi = 32'(khs[KHS_W-1:32]);

  always_comb begin
    unique case (mul_step)
      uas_pkg::MUL_KH: begin
        mul_a = 32'(gain_k);
        mul_b = 32'(gain_h);
      end
      uas_pkg::MUL_KHS: begin
        mul_a = prod[31:0];
        mul_b = 32'(span_q);
      end
      uas_pkg::MUL_P00: begin
        mul_a = prod[31:0];
        mul_b = uas_pkg::TWO_PI_LO;
      end
      uas_pkg::MUL_P01: begin
        mul_a = khs[31:0];
        mul_b = uas_pkg::TWO_PI_HI;
      end
      uas_pkg::MUL_P10: begin
        mul_a = khs_hi;
        mul_b = uas_pkg::TWO_PI_LO;
      end
      uas_pkg::MUL_P11: begin
        mul_a = khs_hi;
        mul_b = uas_pkg::TWO_PI_HI;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (mul_step) inside
      uas_pkg::MUL_P01:                   acc_add = ACC_W'(prod);
      uas_pkg::MUL_P10, uas_pkg::MUL_P11: acc_add = ACC_W'(prod) << 32;
      uas_pkg::MUL_LAST:                  acc_add = ACC_W'(prod) << 64;
      default:                            acc_add = '0;
    endcase
  end

  // result
  logic [27:0] acc_q;
  logic        load_out;

  assign acc_q = acc[ACC_W-1:RND_SH];

  // sequencer
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      uas_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = uas_pkg::ST_ROT;
      end
      uas_pkg::ST_ROT: begin
        if (step_cnt == STEP_LAST) state_next = uas_pkg::ST_UPD;
      end
      uas_pkg::ST_UPD: begin
        state_next = vtx_last ? uas_pkg::ST_CLOSE : uas_pkg::ST_IDLE;
      end
      uas_pkg::ST_CLOSE: state_next = uas_pkg::ST_SPAN;
      uas_pkg::ST_SPAN:  state_next = uas_pkg::ST_MUL;
      uas_pkg::ST_MUL: begin
        if (mul_step == uas_pkg::MUL_LAST) state_next = uas_pkg::ST_DONE;
      end
      uas_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = uas_pkg::ST_IDLE;
        end
      end
      default: state_next = uas_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_k <= uas_pkg::GAIN_RESET;
      gain_h <= uas_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uas_pkg::REG_GAIN_K: gain_k <= cfg_data;
        uas_pkg::REG_GAIN_H: gain_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath without reset
  always_ff @(posedge clk) begin
    unique case (state)
      uas_pkg::ST_IDLE: begin
        cx         <= x_init;
        cy         <= y_init;
        cz         <= x_neg ? 32'h8000_0000 : 32'h0;
        vtx_origin <= (coord_x == 16'sd0) && (coord_y == 16'sd0);
        vtx_last   <= last_vertex;
      end
      uas_pkg::ST_ROT: begin
        if (!cy[CW-1]) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_step;
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_step;
        end
      end
      uas_pkg::ST_SPAN: span_q <= SPAN_W'(span_clamp);
      uas_pkg::ST_MUL: begin
        prod <= mul_p;
        if (mul_step == uas_pkg::MUL_P00) begin
          khs <= prod[KHS_W-1:0];
          acc <= ACC_ROUND;
        end else begin
          acc <= acc + acc_add;
        end
      end
      default: ;
    endcase
  end

  // control and polygon state
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt        <= '0;
      mul_step        <= uas_pkg::MUL_KH;
      first_angle     <= '0;
      previous_angle  <= '0;
      running_angle   <= '0;
      lowest_angle    <= '0;
      highest_angle   <= '0;
      polygon_started <= 1'b0;
      origin_seen     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load_out) out_valid <= 1'b0;
      unique case (state)
        uas_pkg::ST_IDLE: begin
          step_cnt <= '0;
          mul_step <= uas_pkg::MUL_KH;
        end
        uas_pkg::ST_ROT: step_cnt <= step_cnt + 1'b1;
        uas_pkg::ST_UPD: begin
          previous_angle <= vtx_angle;
          if (!polygon_started) begin
            first_angle     <= vtx_angle;
            running_angle   <= start_run;
            lowest_angle    <= start_run;
            highest_angle   <= start_run;
            polygon_started <= 1'b1;
            origin_seen     <= vtx_origin;
          end else begin
            running_angle <= adv_run;
            lowest_angle  <= adv_lo;
            highest_angle <= adv_hi;
            if (vtx_origin) origin_seen <= 1'b1;
          end
        end
        uas_pkg::ST_CLOSE: begin
          running_angle <= adv_run;
          lowest_angle  <= adv_lo;
          highest_angle <= adv_hi;
        end
        uas_pkg::ST_MUL: mul_step <= mul_step + 1'b1;
        uas_pkg::ST_DONE: begin
          if (load_out) begin
            out_valid       <= 1'b1;
            first_angle     <= '0;
            previous_angle  <= '0;
            running_angle   <= '0;
            lowest_angle    <= '0;
            highest_angle   <= '0;
            polygon_started <= 1'b0;
            origin_seen     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      span_angle    <= span_wide[16:0];
      scaled_result <= acc_q[27] ? uas_pkg::SCALED_CAP : acc_q[26:0];
      origin_hit    <= origin_seen;
    end
  end

  `UAS_ASSERT_NOW(a_rise_from_done, $rose(out_valid), $past(state) == uas_pkg::ST_DONE, "result beat not from done state")
  `UAS_ASSERT_NEXT(a_clear_after_load, load_out, !polygon_started && running_angle == 24'sd0, "polygon state not cleared")
  `UAS_ASSERT_NOW(a_run_in_bounds, polygon_started, lowest_angle <= running_angle && running_angle <= highest_angle, "running angle outside min and max")
  `UAS_ASSERT_NOW(a_step_bound, state == uas_pkg::ST_ROT, step_cnt <= STEP_LAST, "cordic step count overrun")
  `UAS_ASSERT_NOW(a_span_clamped, state == uas_pkg::ST_MUL, span_wide <= FULL_TURN, "span above one turn")

endmodule
